// ----- src/ctdll_pkg.sv -----
// shared types and constants for the cycle timer rate estimator
// no dependencies; used by the controller, datapath, divider and top level
package ctdll_pkg;

	// fixed point of rate values and of the loop gain
	localparam int FRAC_BITS  = 24;
	localparam int GAIN_SHIFT = 24;

	// bus cycle timer geometry
	localparam logic [31:0] TICKS_PER_SEC = 32'd24576000;

	// the 128 s wrap is 750 * 2^22 ticks, so a reduction only touches the upper bits
	localparam int          WRAP_SHIFT = 22;
	localparam logic [9:0]  WRAP_UNIT  = 10'd750;
	localparam logic [31:0] WRAP_TICKS = {WRAP_UNIT, {WRAP_SHIFT{1'b0}}};
	// ceil(2^28 / 750), exact quotient for any 17-bit value
	localparam int          RECIP_SHIFT = 28;
	localparam logic [18:0] WRAP_RECIP  = 19'd357914;

	// register reset values
	localparam logic [31:0] NOMINAL_RESET   = 32'd412316860;
	localparam logic [31:0] TOLERANCE_RESET = 32'd8246337;
	localparam logic [24:0] GAIN_RESET      = 25'd16777;

	// measured rate quotient: 32-bit tick span shifted by the fraction bits
	localparam int QUOT_W    = 32 + FRAC_BITS;
	localparam int DIV_STEPS = QUOT_W / 2;
	// tick offset from rate * |elapsed|
	localparam int OFF_W     = 63 - FRAC_BITS;

	typedef enum logic [1:0] {
		OP_MEASURE = 2'd0,
		OP_PREDICT = 2'd1,
		OP_RELOAD  = 2'd2
	} op_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic conv;
		logic div_start;
		logic reload;
		logic check;
		logic mul;
		logic red1;
		logic red2;
		logic sum;
		logic commit_meas;
		logic res_load;
		logic res_pred;
		logic res_acc;
	} dp_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		op_t  op;
		logic d_nonpos;
		logic div_done;
		logic in_range;
	} dp_sts_t;

endpackage

// ----- src/ctdll_div.sv -----
// radix-4 restoring divider for the measured rate: (span << FRAC_BITS) / elapsed
// depends on ctdll_pkg
module ctdll_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [31:0]                   span,
	input  logic [30:0]                   divisor,
	output logic [ctdll_pkg::QUOT_W-1:0]  quotient,
	output logic                          done
);

	localparam int QW = ctdll_pkg::QUOT_W;

	logic [QW-1:0] dq_q;
	logic [30:0]   rem_q;
	logic [30:0]   dvs_q;
	logic [4:0]    cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [31:0] t1, t2, r1, r2;
	logic        ge1, ge2;

	// two quotient bits per cycle
	always_comb begin
		t1  = {rem_q, dq_q[QW-1]};
		ge1 = t1 >= {1'b0, dvs_q};
		r1  = ge1 ? t1 - {1'b0, dvs_q} : t1;
		t2  = {r1[30:0], dq_q[QW-2]};
		ge2 = t2 >= {1'b0, dvs_q};
		r2  = ge2 ? t2 - {1'b0, dvs_q} : t2;
	end

	// operand and partial remainder registers
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= {span, {ctdll_pkg::FRAC_BITS{1'b0}}};
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[QW-3:0], ge1, ge2};
			rem_q <= r2[30:0];
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == 5'(ctdll_pkg::DIV_STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(ctdll_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign quotient = dq_q;
	assign done     = done_q;

	// done marks the quotient ready once all DIV_STEPS steps after start have run
	a_div_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(ctdll_pkg::DIV_STEPS + 1) done_q)
		else $error("divider done not at expected cycle");

	a_div_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while still busy");

endmodule

// ----- src/ctdll_dp.sv -----
// datapath: anchor and rate state, tick conversion, range check, products,
// wrap reduction and result register; depends on ctdll_pkg and ctdll_div
module ctdll_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  ctdll_pkg::dp_cmd_t  cmd,
	output ctdll_pkg::dp_sts_t  sts,
	input  logic [1:0]          op,
	input  logic [31:0]         cycle_timer,
	input  logic [31:0]         now_usecs,
	input  logic [31:0]         nominal_rate,
	input  logic [31:0]         rate_tolerance,
	input  logic [24:0]         dll_gain,
	output logic [31:0]         ticks,
	output logic                accepted,
	output logic [31:0]         rate_now
);

	localparam int QW   = ctdll_pkg::QUOT_W;
	localparam int OW   = ctdll_pkg::OFF_W;
	localparam int VW   = OW - ctdll_pkg::WRAP_SHIFT;
	localparam int FB   = ctdll_pkg::FRAC_BITS;
	localparam int GS   = ctdll_pkg::GAIN_SHIFT;

	// raw timer to ticks, one wrap at most to remove
	function automatic logic [31:0] timer_ticks(input logic [31:0] ct);
		logic [31:0] raw;
		raw = {25'd0, ct[31:25]} * ctdll_pkg::TICKS_PER_SEC
			+ {8'd0, ct[24:12], 11'd0} + {9'd0, ct[24:12], 10'd0}
			+ {20'd0, ct[11:0]};
		return (raw >= ctdll_pkg::WRAP_TICKS) ? raw - ctdll_pkg::WRAP_TICKS : raw;
	endfunction

	// captured beat
	ctdll_pkg::op_t op_q;
	logic [31:0]    ct_q;
	logic [31:0]    now_q;

	// loop state
	logic [31:0] anchor_ticks_q;
	logic [31:0] anchor_usecs_q;
	logic [31:0] rate_q;

	// working registers
	logic [31:0] nt_q, d_q, dabs_q, lo_q;
	logic        lo_neg_q;
	logic [32:0] hi_q;
	logic        in_range_q, err_neg_q;
	logic [32:0] mag_q;
	logic [57:0] prod_q;
	logic [OW-1:0] off_q;
	logic [7:0]  qm_q;
	logic [31:0] rate_new_q;
	logic [31:0] m_q;
	logic [31:0] sum_q;

	// result register
	logic [31:0] ticks_q, rate_now_q;
	logic        accepted_q;

	// divider
	logic [QW-1:0] quot;
	logic          div_done;
	logic [32:0]   span_full;
	logic [31:0]   d_now;

	assign d_now     = now_q - anchor_usecs_q;
	assign span_full = {1'b0, nt_q}
		+ ((nt_q > anchor_ticks_q) ? 33'd0 : {1'b0, ctdll_pkg::WRAP_TICKS})
		- {1'b0, anchor_ticks_q};

	ctdll_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.span     (span_full[31:0]),
		.divisor  (d_q[30:0]),
		.quotient (quot),
		.done     (div_done)
	);

	// range check and rate error
	logic [32:0] q_low;
	logic        q_big, gt_lo, lt_hi;
	logic [33:0] err;
	always_comb begin
		q_low = quot[32:0];
		q_big = |quot[QW-1:33];
		gt_lo = lo_neg_q || (q_low > {1'b0, lo_q});
		lt_hi = q_low < hi_q;
		err   = {1'b0, q_low} - {2'b0, rate_q};
	end

	// products
	logic [63:0] off_prod;
	assign off_prod = 64'(rate_q) * 64'(dabs_q);

	// rate step with rounding, and saturated new rate
	logic [58:0] rnd;
	logic [34:0] step;
	logic [36:0] nr;
	logic [31:0] nr_sat;
	always_comb begin
		rnd  = {1'b0, prod_q} + (59'd1 << (GS - 1));
		step = rnd[58:GS];
		if (err_neg_q) begin
			nr     = {5'd0, rate_q} - {2'd0, step};
			nr_sat = nr[36] ? 32'd0 : nr[31:0];
		end else begin
			nr     = {5'd0, rate_q} + {2'd0, step};
			nr_sat = (nr[36:32] != 5'd0) ? 32'hFFFF_FFFF : nr[31:0];
		end
	end

	// reduction of the offset modulo the wrap
	logic [VW-1:0] v;
	logic [35:0]   rcp_prod;
	logic [16:0]   qm750;
	logic [16:0]   vrem;
	assign v        = off_q[OW-1:ctdll_pkg::WRAP_SHIFT];
	assign rcp_prod = 36'(v) * 36'(ctdll_pkg::WRAP_RECIP);
	assign qm750    = 17'(qm_q) * 17'(ctdll_pkg::WRAP_UNIT);
	assign vrem     = 17'(v) - qm750;

	// anchor plus or minus reduced offset, wrapped
	logic [32:0] s_add, s_sub;
	logic [31:0] s_res;
	always_comb begin
		s_add = {1'b0, anchor_ticks_q} + {1'b0, m_q};
		s_sub = {1'b0, anchor_ticks_q} - {1'b0, m_q};
		if (d_q[31]) begin
			s_res = s_sub[32] ? s_sub[31:0] + ctdll_pkg::WRAP_TICKS : s_sub[31:0];
		end else begin
			s_res = (s_add >= {1'b0, ctdll_pkg::WRAP_TICKS})
				? 32'(s_add - {1'b0, ctdll_pkg::WRAP_TICKS}) : s_add[31:0];
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= ctdll_pkg::op_t'(op);
			ct_q  <= cycle_timer;
			now_q <= now_usecs;
		end
		if (cmd.conv) begin
			nt_q     <= timer_ticks(ct_q);
			d_q      <= d_now;
			dabs_q   <= d_now[31] ? 32'(-d_now) : d_now;
			lo_neg_q <= rate_tolerance > nominal_rate;
			lo_q     <= nominal_rate - rate_tolerance;
			hi_q     <= {1'b0, nominal_rate} + {1'b0, rate_tolerance};
		end
		if (cmd.check) begin
			in_range_q <= !q_big && gt_lo && lt_hi;
			err_neg_q  <= err[33];
			mag_q      <= err[33] ? 33'(-err) : err[32:0];
		end
		if (cmd.mul) begin
			prod_q <= 58'(dll_gain) * 58'(mag_q);
			off_q  <= off_prod[62:FB];
		end
		if (cmd.red1) begin
			qm_q       <= rcp_prod[ctdll_pkg::RECIP_SHIFT +: 8];
			rate_new_q <= nr_sat;
		end
		if (cmd.red2) begin
			m_q <= {vrem[9:0], off_q[ctdll_pkg::WRAP_SHIFT-1:0]};
		end
		if (cmd.sum) begin
			sum_q <= s_res;
		end
		if (cmd.res_load) begin
			ticks_q    <= cmd.res_pred ? sum_q : anchor_ticks_q;
			accepted_q <= cmd.res_acc;
			rate_now_q <= rate_q;
		end
	end

	// anchor and rate state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_ticks_q <= '0;
			anchor_usecs_q <= '0;
			rate_q         <= ctdll_pkg::NOMINAL_RESET;
		end else if (cmd.reload) begin
			anchor_ticks_q <= nt_q;
			anchor_usecs_q <= now_q;
			rate_q         <= nominal_rate;
		end else if (cmd.commit_meas) begin
			anchor_ticks_q <= s_res;
			anchor_usecs_q <= now_q;
			rate_q         <= rate_new_q;
		end
	end

	always_comb begin
		sts.op       = op_q;
		sts.d_nonpos = d_q[31] || (d_q == 32'd0);
		sts.div_done = div_done;
		sts.in_range = in_range_q;
	end

	assign ticks    = ticks_q;
	assign accepted = accepted_q;
	assign rate_now = rate_now_q;

	// anchor always stays inside one wrap
	a_anchor_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		anchor_ticks_q < ctdll_pkg::WRAP_TICKS)
		else $error("anchor ticks outside wrap");

endmodule

// ----- src/ctdll_ctrl.sv -----
// controller state machine: sequences conversion, division, products,
// reduction and commit; depends on ctdll_pkg
module ctdll_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  ctdll_pkg::dp_sts_t  sts,
	output ctdll_pkg::dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CONV,
		S_DISP,
		S_DIV,
		S_CHECK,
		S_RANGE,
		S_MUL,
		S_RED1,
		S_RED2,
		S_SUM,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   acc_q;
	logic   slot_free;
	logic   is_meas;

	assign slot_free = !out_valid_q || !out_stall;
	assign is_meas   = sts.op == ctdll_pkg::OP_MEASURE;

	// commands decoded from state
	always_comb begin
		cmd             = '0;
		cmd.capture     = (state_q == S_IDLE) && in_valid;
		cmd.conv        = state_q == S_CONV;
		cmd.div_start   = (state_q == S_DISP) && is_meas && !sts.d_nonpos;
		cmd.reload      = (state_q == S_DISP) && (sts.op == ctdll_pkg::OP_RELOAD);
		cmd.check       = state_q == S_CHECK;
		cmd.mul         = state_q == S_MUL;
		cmd.red1        = state_q == S_RED1;
		cmd.red2        = state_q == S_RED2;
		cmd.sum         = state_q == S_SUM;
		cmd.commit_meas = (state_q == S_SUM) && is_meas;
		cmd.res_load    = (state_q == S_DONE) && slot_free;
		cmd.res_pred    = sts.op == ctdll_pkg::OP_PREDICT;
		cmd.res_acc     = acc_q;
	end

	// state, output valid and accept flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			acc_q       <= 1'b0;
		end else begin
			// result register: set by a finished item, cleared when taken
			if (state_q == S_DONE && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CONV;
						acc_q   <= 1'b0;
					end
				end
				S_CONV: state_q <= S_DISP;
				S_DISP: begin
					case (sts.op)
						ctdll_pkg::OP_MEASURE: state_q <= sts.d_nonpos ? S_DONE : S_DIV;
						ctdll_pkg::OP_PREDICT: state_q <= S_MUL;
						default:               state_q <= S_DONE;
					endcase
				end
				S_DIV: begin
					if (sts.div_done) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: state_q <= S_RANGE;
				S_RANGE: state_q <= sts.in_range ? S_MUL : S_DONE;
				S_MUL:   state_q <= S_RED1;
				S_RED1:  state_q <= S_RED2;
				S_RED2:  state_q <= S_SUM;
				S_SUM: begin
					state_q <= S_DONE;
					if (is_meas) begin
						acc_q <= 1'b1;
					end
				end
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;

	// rate update only after a passing range check
	a_commit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit_meas |-> sts.in_range)
		else $error("rate committed without range check");

	// divider finishes only while waiting for it
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> state_q == S_DIV)
		else $error("divider done outside divide state");

	// a finished item lands in the result register and frees the input
	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && slot_free) |=> (out_valid_q && state_q == S_IDLE))
		else $error("result not released");

endmodule

// ----- src/cycle_timer_dll_estimator.sv -----
// Bus cycle timer rate estimator, a first-order delay-locked loop against local
// microsecond time. One item is worked on at a time; the result register then
// frees the input, so the next beat is taken while a result waits. A measurement
// that updates the loop runs the 28-step, two-bits-per-cycle divider for the
// measured rate, its longest part, then the range check, products, reduction and
// commit; one rejected by the range check ends there; a prediction runs products,
// reduction and sum; a reload, an unused op or a measurement with non-positive
// elapsed time goes straight to the result. Configuration writes are always ready.
//
// top level: configuration registers, controller and datapath; depends on
// ctdll_pkg, ctdll_ctrl, ctdll_dp and ctdll_div
module cycle_timer_dll_estimator (
	input  logic        clk,
	input  logic        arst_n,
	// item input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [31:0] cycle_timer,
	input  logic [31:0] now_usecs,
	// result output
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] ticks,
	output logic        accepted,
	output logic [31:0] rate_now,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	typedef enum logic [1:0] {
		CFG_NOMINAL   = 2'd0,
		CFG_TOLERANCE = 2'd1,
		CFG_GAIN      = 2'd2
	} cfg_idx_t;

	logic [31:0] nominal_q;
	logic [31:0] tolerance_q;
	logic [24:0] gain_q;

	ctdll_pkg::dp_cmd_t cmd;
	ctdll_pkg::dp_sts_t sts;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nominal_q   <= ctdll_pkg::NOMINAL_RESET;
			tolerance_q <= ctdll_pkg::TOLERANCE_RESET;
			gain_q      <= ctdll_pkg::GAIN_RESET;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_NOMINAL:   nominal_q   <= cfg_data;
				CFG_TOLERANCE: tolerance_q <= cfg_data;
				CFG_GAIN:      gain_q      <= cfg_data[24:0];
				default: ;
			endcase
		end
	end

	ctdll_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ctdll_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.op             (op),
		.cycle_timer    (cycle_timer),
		.now_usecs      (now_usecs),
		.nominal_rate   (nominal_q),
		.rate_tolerance (tolerance_q),
		.dll_gain       (gain_q),
		.ticks          (ticks),
		.accepted       (accepted),
		.rate_now       (rate_now)
	);

endmodule
